FILE: rtl/core/lcim_pkg.sv
// Link-cell index mapper: shared widths, command and region codes, sideband type.
// No dependencies; imported by lcim_div and link_cell_index_mapper.
package lcim_pkg;

    localparam int IDX_W  = 19;
    localparam int CRD_W  = 8;
    localparam int GRID_W = 7;
    localparam int GW     = 22;
    localparam int DIV_W  = 8;

    localparam logic [1:0] CMD_TUP = 2'd0;
    localparam logic [1:0] CMD_IDX = 2'd1;
    localparam logic [1:0] CMD_NBR = 2'd2;
    localparam logic [1:0] CMD_BAD = 2'd3;

    localparam logic [1:0] REG_GRID_X = 2'd0;
    localparam logic [1:0] REG_GRID_Y = 2'd1;
    localparam logic [1:0] REG_GRID_Z = 2'd2;

    localparam logic [2:0] RG_LOC = 3'd0;
    localparam logic [2:0] RG_XLO = 3'd1;
    localparam logic [2:0] RG_XHI = 3'd2;
    localparam logic [2:0] RG_YLO = 3'd3;
    localparam logic [2:0] RG_YHI = 3'd4;
    localparam logic [2:0] RG_ZLO = 3'd5;
    localparam logic [2:0] RG_ZHI = 3'd6;

    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_LOC  = 3'd1;
    localparam logic [2:0] KIND_X    = 3'd2;
    localparam logic [2:0] KIND_Y    = 3'd3;
    localparam logic [2:0] KIND_Z    = 3'd4;

    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [CRD_W-1:0] z;
        logic [IDX_W-1:0]        idx;
        logic                    err;
        logic [2:0]              rg;
    } front_t;

    typedef struct packed {
        logic [1:0]              cmd;
        logic                    err;
        logic [2:0]              kind;
        logic signed [CRD_W-1:0] fix;
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        logic signed [CRD_W-1:0] z;
    } side_t;

endpackage

FILE: rtl/core/lcim_div.sv
// Pipelined restoring divider, STEP quotient bits per stage, with sideband.
// Depends on lcim_pkg (DIV_W).
module lcim_div
    import lcim_pkg::*;
#(
    parameter int NUM_W  = 19,
    parameter int STEP   = 4,
    parameter int SIDE_W = 8
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DIV_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [NUM_W-1:0]  out_quo,
    output logic [DIV_W-1:0]  out_rem,
    output logic [SIDE_W-1:0] out_side
);

    localparam int NSTG = (NUM_W + STEP - 1) / STEP;
    localparam int PW   = NSTG * STEP;

    logic [NSTG-1:0]   vld_reg;
    logic [NSTG-1:0]   vld_src;
    logic [PW-1:0]     nq_reg   [NSTG];
    logic [PW-1:0]     nq_src   [NSTG];
    logic [PW-1:0]     nq_next  [NSTG];
    logic [DIV_W-1:0]  rem_reg  [NSTG];
    logic [DIV_W-1:0]  rem_src  [NSTG];
    logic [DIV_W-1:0]  rem_next [NSTG];
    logic [DIV_W-1:0]  den_reg  [NSTG];
    logic [DIV_W-1:0]  den_src  [NSTG];
    logic [SIDE_W-1:0] side_reg [NSTG];
    logic [SIDE_W-1:0] side_src [NSTG];

    always_comb begin
        vld_src[0]  = in_vld;
        nq_src[0]   = PW'(in_num);
        rem_src[0]  = '0;
        den_src[0]  = in_den;
        side_src[0] = in_side;
        for (int s = 1; s < NSTG; s++) begin
            vld_src[s]  = vld_reg[s-1];
            nq_src[s]   = nq_reg[s-1];
            rem_src[s]  = rem_reg[s-1];
            den_src[s]  = den_reg[s-1];
            side_src[s] = side_reg[s-1];
        end
    end

    always_comb begin : div_steps
        logic [PW-1:0]    nq;
        logic [DIV_W-1:0] rem;
        logic [DIV_W:0]   t;
        for (int s = 0; s < NSTG; s++) begin
            nq  = nq_src[s];
            rem = rem_src[s];
            for (int b = 0; b < STEP; b++) begin
                t  = {rem, nq[PW-1]};
                nq = {nq[PW-2:0], 1'b0};
                if (t >= {1'b0, den_src[s]}) begin
                    t     = t - {1'b0, den_src[s]};
                    nq[0] = 1'b1;
                end
                rem = t[DIV_W-1:0];
            end
            nq_next[s]  = nq;
            rem_next[s] = rem;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_src;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < NSTG; s++) begin
                nq_reg[s]   <= nq_next[s];
                rem_reg[s]  <= rem_next[s];
                den_reg[s]  <= den_src[s];
                side_reg[s] <= side_src[s];
            end
        end
    end

    assign out_vld  = vld_reg[NSTG-1];
    assign out_quo  = nq_reg[NSTG-1][NUM_W-1:0];
    assign out_rem  = rem_reg[NSTG-1];
    assign out_side = side_reg[NSTG-1];

endmodule

FILE: rtl/core/link_cell_index_mapper.sv
// Link-cell index mapper top level: config registers, decode, two dividers,
// neighbour expander and index pipeline. Depends on lcim_pkg and lcim_div.
//
// Usage:
//   cfg_*  : writes grid_x/y/z (index 0..2, others ignored); always ready.
//            Write only while the block is idle. Sizes are clamped to 2..GRID_MAX.
//   s_*    : one command item per handshake (tuple to index, index to tuple,
//            periodic neighbour list).
//   m_*    : result items, one per cycle at most; m_out_last marks the final
//            result of each input item.
// Pipeline from input accept to first result: five decode stages, two five-stage
// dividers, the expander and four index stages. Throughput: one result per cycle
// while m_ready is high. Commands 0, 1 and errors give one result each; a
// neighbour list gives 27 results and holds the expander until the last, so a
// new item cannot enter the expander before the list is through.
// Reset: all grid sizes return to 2 and the pipeline empties.
// Stall: when m_ready is low the index stages and expander hold; a busy expander
// with d2_vld set holds the front stages and s_ready falls. Nothing is lost.
module link_cell_index_mapper
    import lcim_pkg::*;
#(
    parameter int GRID_MAX = 64
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [GRID_W-1:0]       cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_command,
    input  logic signed [CRD_W-1:0] s_in_x,
    input  logic signed [CRD_W-1:0] s_in_y,
    input  logic signed [CRD_W-1:0] s_in_z,
    input  logic [IDX_W-1:0]        s_in_index,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [IDX_W-1:0]        m_out_index,
    output logic signed [CRD_W-1:0] m_out_x,
    output logic signed [CRD_W-1:0] m_out_y,
    output logic signed [CRD_W-1:0] m_out_z,
    output logic                    m_out_last,
    output logic                    m_out_range_error
);

    localparam logic [GRID_W-1:0] GMAX =
        (GRID_MAX > 127) ? GRID_W'(127) : GRID_W'(GRID_MAX);
    localparam int DIV_STEP = 4;

    // ---------------- configuration and geometry ----------------
    logic [GRID_W-1:0] gx_reg, gy_reg, gz_reg;
    logic [GRID_W-1:0] cfg_clamp;

    always_comb begin
        if (cfg_data < GRID_W'(2)) cfg_clamp = GRID_W'(2);
        else if (cfg_data > GMAX)  cfg_clamp = GMAX;
        else                       cfg_clamp = cfg_data;
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gx_reg <= GRID_W'(2);
            gy_reg <= GRID_W'(2);
            gz_reg <= GRID_W'(2);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GRID_X: gx_reg <= cfg_clamp;
                REG_GRID_Y: gy_reg <= cfg_clamp;
                REG_GRID_Z: gz_reg <= cfg_clamp;
                default: ;
            endcase
        end
    end

    logic [DIV_W-1:0] ga, gb;
    logic signed [CRD_W-1:0] gxs, gys, gzs;
    assign ga  = {1'b0, gx_reg} + DIV_W'(2);
    assign gb  = {1'b0, gy_reg} + DIV_W'(2);
    assign gxs = $signed({1'b0, gx_reg});
    assign gys = $signed({1'b0, gy_reg});
    assign gzs = $signed({1'b0, gz_reg});

    logic [GW-1:0] gxgy_reg, gygz_reg, gza_reg, ab_reg;
    logic [GW-1:0] loc_reg, ox2_reg, oy1_reg, oy2_reg, oz1_reg, oz2_reg, otot_reg;
    logic [GW-1:0] bx2_reg, by1_reg, by2_reg, bz1_reg, bz2_reg, tot_reg;

    always_ff @(posedge aclk) begin
        gxgy_reg <= GW'(gx_reg) * GW'(gy_reg);
        gygz_reg <= GW'(gy_reg) * GW'(gz_reg);
        gza_reg  <= GW'(gz_reg) * GW'(ga);
        ab_reg   <= GW'(ga) * GW'(gb);
        loc_reg  <= gxgy_reg * GW'(gz_reg);
        ox2_reg  <= gygz_reg;
        oy1_reg  <= gygz_reg << 1;
        oy2_reg  <= (gygz_reg << 1) + gza_reg;
        oz1_reg  <= (gygz_reg << 1) + (gza_reg << 1);
        oz2_reg  <= (gygz_reg << 1) + (gza_reg << 1) + ab_reg;
        otot_reg <= (gygz_reg << 1) + (gza_reg << 1) + (ab_reg << 1);
        bx2_reg  <= loc_reg + ox2_reg;
        by1_reg  <= loc_reg + oy1_reg;
        by2_reg  <= loc_reg + oy2_reg;
        bz1_reg  <= loc_reg + oz1_reg;
        bz2_reg  <= loc_reg + oz2_reg;
        tot_reg  <= loc_reg + otot_reg;
    end

    // ---------------- front stages ----------------
    logic   en_f, en_b;
    front_t s1_reg, s2_reg, s3_reg, s4_reg;
    front_t s2_next, s4_next;
    logic   s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    side_t  s5_side_reg, s5_side_next;
    logic [IDX_W-1:0] s5_num_reg, s5_num_next;
    logic [DIV_W-1:0] s5_den_reg, s5_den_next;

    assign s_ready = en_f;

    always_comb begin
        s2_next = s1_reg;
        if (s1_reg.cmd == CMD_TUP) begin
            s2_next.err = (s1_reg.x < -8'sd1) || (s1_reg.x > gxs) ||
                          (s1_reg.y < -8'sd1) || (s1_reg.y > gys) ||
                          (s1_reg.z < -8'sd1) || (s1_reg.z > gzs);
        end else begin
            s2_next.err = (s1_reg.cmd == CMD_BAD);
        end
    end

    always_comb begin : s4_logic
        logic [GW-1:0] iw;
        iw      = GW'(s3_reg.idx);
        s4_next = s3_reg;
        if (s3_reg.cmd == CMD_IDX && iw >= tot_reg) s4_next.err = 1'b1;
        if (s3_reg.cmd == CMD_NBR && iw >= loc_reg) s4_next.err = 1'b1;
        if (iw < loc_reg)      s4_next.rg = RG_LOC;
        else if (iw < bx2_reg) s4_next.rg = RG_XLO;
        else if (iw < by1_reg) s4_next.rg = RG_XHI;
        else if (iw < by2_reg) s4_next.rg = RG_YLO;
        else if (iw < bz1_reg) s4_next.rg = RG_YHI;
        else if (iw < bz2_reg) s4_next.rg = RG_ZLO;
        else                   s4_next.rg = RG_ZHI;
    end

    always_comb begin : s5_logic
        logic [GW-1:0] base;
        s5_side_next.cmd  = s4_reg.cmd;
        s5_side_next.err  = s4_reg.err;
        s5_side_next.x    = s4_reg.x;
        s5_side_next.y    = s4_reg.y;
        s5_side_next.z    = s4_reg.z;
        s5_side_next.fix  = -8'sd1;
        s5_side_next.kind = KIND_NONE;
        base        = '0;
        s5_den_next = ga;
        case (s4_reg.rg)
            RG_LOC: begin
                s5_side_next.kind = KIND_LOC;
                s5_den_next       = {1'b0, gx_reg};
            end
            RG_XLO: begin
                s5_side_next.kind = KIND_X;
                base              = loc_reg;
                s5_den_next       = {1'b0, gy_reg};
            end
            RG_XHI: begin
                s5_side_next.kind = KIND_X;
                s5_side_next.fix  = gxs;
                base              = bx2_reg;
                s5_den_next       = {1'b0, gy_reg};
            end
            RG_YLO: begin
                s5_side_next.kind = KIND_Y;
                base              = by1_reg;
            end
            RG_YHI: begin
                s5_side_next.kind = KIND_Y;
                s5_side_next.fix  = gys;
                base              = by2_reg;
            end
            RG_ZLO: begin
                s5_side_next.kind = KIND_Z;
                base              = bz1_reg;
            end
            default: begin
                s5_side_next.kind = KIND_Z;
                s5_side_next.fix  = gzs;
                base              = bz2_reg;
            end
        endcase
        if (s4_reg.cmd == CMD_TUP || s4_reg.err) s5_side_next.kind = KIND_NONE;
        s5_num_next = IDX_W'(GW'(s4_reg.idx) - base);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end else if (en_f) begin
            s1_vld_reg <= s_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_f) begin
            s1_reg.cmd  <= s_command;
            s1_reg.x    <= s_in_x;
            s1_reg.y    <= s_in_y;
            s1_reg.z    <= s_in_z;
            s1_reg.idx  <= s_in_index;
            s1_reg.err  <= 1'b0;
            s1_reg.rg   <= RG_LOC;
            s2_reg      <= s2_next;
            s3_reg      <= s2_reg;
            s4_reg      <= s4_next;
            s5_side_reg <= s5_side_next;
            s5_num_reg  <= s5_num_next;
            s5_den_reg  <= s5_den_next;
        end
    end

    // ---------------- dividers ----------------
    logic             d1_vld, d2_vld;
    logic [IDX_W-1:0] d1_quo, d2_quo;
    logic [DIV_W-1:0] d1_rem, d2_rem;
    side_t            d1_side, d2_side, mix_side;

    lcim_div #(.NUM_W(IDX_W), .STEP(DIV_STEP), .SIDE_W($bits(side_t))) u_div1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en_f),
        .in_vld   (s5_vld_reg),
        .in_num   (s5_num_reg),
        .in_den   (s5_den_reg),
        .in_side  (s5_side_reg),
        .out_vld  (d1_vld),
        .out_quo  (d1_quo),
        .out_rem  (d1_rem),
        .out_side (d1_side)
    );

    always_comb begin
        mix_side = d1_side;
        case (d1_side.kind)
            KIND_LOC: mix_side.x = $signed(d1_rem);
            KIND_X: begin
                mix_side.x = d1_side.fix;
                mix_side.y = $signed(d1_rem);
                mix_side.z = $signed(d1_quo[CRD_W-1:0]);
            end
            KIND_Y: begin
                mix_side.y = d1_side.fix;
                mix_side.x = $signed(d1_rem) - 8'sd1;
                mix_side.z = $signed(d1_quo[CRD_W-1:0]);
            end
            KIND_Z: begin
                mix_side.z = d1_side.fix;
                mix_side.x = $signed(d1_rem) - 8'sd1;
                mix_side.y = $signed(d1_quo[CRD_W-1:0]) - 8'sd1;
            end
            default: ;
        endcase
    end

    lcim_div #(.NUM_W(IDX_W), .STEP(DIV_STEP), .SIDE_W($bits(side_t))) u_div2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en_f),
        .in_vld   (d1_vld),
        .in_num   (d1_quo),
        .in_den   ({1'b0, gy_reg}),
        .in_side  (mix_side),
        .out_vld  (d2_vld),
        .out_quo  (d2_quo),
        .out_rem  (d2_rem),
        .out_side (d2_side)
    );

    side_t ex_in;
    always_comb begin
        ex_in = d2_side;
        if (d2_side.kind == KIND_LOC) begin
            ex_in.y = $signed(d2_rem);
            ex_in.z = $signed(d2_quo[CRD_W-1:0]);
        end
    end

    // ---------------- neighbour expander ----------------
    function automatic logic signed [CRD_W-1:0] wrap_c(
        input logic signed [CRD_W-1:0] c,
        input logic [1:0]              off,
        input logic [GRID_W-1:0]       g
    );
        logic signed [CRD_W-1:0] v;
        logic signed [CRD_W-1:0] gs;
        gs = $signed({1'b0, g});
        v  = c + $signed({{(CRD_W-2){1'b0}}, off}) - 8'sd1;
        if (v == -8'sd1)  wrap_c = gs - 8'sd1;
        else if (v == gs) wrap_c = '0;
        else              wrap_c = v;
    endfunction

    side_t      ex_reg;
    logic       ex_vld_reg;
    logic [1:0] ci_reg, cj_reg, ck_reg;
    logic       ex_single, ex_fin, ex_free;
    logic signed [CRD_W-1:0] e_x, e_y, e_z;
    logic       e_last;

    assign ex_single = (ex_reg.cmd != CMD_NBR) || ex_reg.err;
    assign e_last    = ex_single ||
                       (ci_reg == 2'd2 && cj_reg == 2'd2 && ck_reg == 2'd2);
    assign ex_fin    = ex_vld_reg && en_b && e_last;
    assign ex_free   = !ex_vld_reg || ex_fin;
    assign en_f      = ex_free || !d2_vld;

    assign e_x = ex_single ? ex_reg.x : wrap_c(ex_reg.x, ci_reg, gx_reg);
    assign e_y = ex_single ? ex_reg.y : wrap_c(ex_reg.y, cj_reg, gy_reg);
    assign e_z = ex_single ? ex_reg.z : wrap_c(ex_reg.z, ck_reg, gz_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_vld_reg <= 1'b0;
            ci_reg     <= 2'd0;
            cj_reg     <= 2'd0;
            ck_reg     <= 2'd0;
        end else if (ex_free) begin
            ex_vld_reg <= d2_vld;
            ci_reg     <= 2'd0;
            cj_reg     <= 2'd0;
            ck_reg     <= 2'd0;
        end else if (ex_vld_reg && en_b) begin
            if (ck_reg == 2'd2) begin
                ck_reg <= 2'd0;
                if (cj_reg == 2'd2) begin
                    cj_reg <= 2'd0;
                    ci_reg <= ci_reg + 2'd1;
                end else begin
                    cj_reg <= cj_reg + 2'd1;
                end
            end else begin
                ck_reg <= ck_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ex_free) ex_reg <= ex_in;
    end

    // ---------------- index stages ----------------
    logic b1_vld_reg, b2_vld_reg, b3_vld_reg, out_vld_reg;
    logic signed [CRD_W-1:0] b1_x_reg, b1_y_reg, b1_z_reg;
    logic signed [CRD_W-1:0] b2_x_reg, b2_y_reg, b2_z_reg;
    logic signed [CRD_W-1:0] b3_x_reg, b3_y_reg, b3_z_reg;
    logic b1_err_reg, b2_err_reg, b3_err_reg;
    logic b1_last_reg, b2_last_reg, b3_last_reg;

    logic [GW-1:0]    b2_base_reg, b2_base_next, b3_base_reg;
    logic [DIV_W-1:0] b2_m1_reg, b2_m1_next;
    logic [CRD_W-1:0] b2_v1_reg, b2_v1_next;
    logic [13:0]      b2_m2_reg, b2_m2_next;
    logic [CRD_W-1:0] b2_v2_reg, b2_v2_next;
    logic [CRD_W-1:0] b2_v3_reg, b2_v3_next, b3_v3_reg;
    logic [15:0]      b3_p1_reg;
    logic [GW-1:0]    b3_p2_reg;
    logic [GW-1:0]    b3_sum;

    logic [IDX_W-1:0]        out_index_reg;
    logic signed [CRD_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic                    out_last_reg, out_err_reg;

    assign en_b = !out_vld_reg || m_ready;

    always_comb begin
        b2_base_next = '0;
        b2_m1_next   = ga;
        b2_v1_next   = '0;
        b2_m2_next   = '0;
        b2_v2_next   = '0;
        b2_v3_next   = b1_x_reg + 8'sd1;
        if (b1_z_reg == gzs) begin
            b2_base_next = bz2_reg;
            b2_v1_next   = b1_y_reg + 8'sd1;
        end else if (b1_z_reg == -8'sd1) begin
            b2_base_next = bz1_reg;
            b2_v1_next   = b1_y_reg + 8'sd1;
        end else if (b1_y_reg == gys) begin
            b2_base_next = by2_reg;
            b2_v1_next   = b1_z_reg;
        end else if (b1_y_reg == -8'sd1) begin
            b2_base_next = by1_reg;
            b2_v1_next   = b1_z_reg;
        end else if (b1_x_reg == gxs) begin
            b2_base_next = bx2_reg;
            b2_m1_next   = {1'b0, gy_reg};
            b2_v1_next   = b1_z_reg;
            b2_v3_next   = b1_y_reg;
        end else if (b1_x_reg == -8'sd1) begin
            b2_base_next = loc_reg;
            b2_m1_next   = {1'b0, gy_reg};
            b2_v1_next   = b1_z_reg;
            b2_v3_next   = b1_y_reg;
        end else begin
            b2_m1_next = {1'b0, gx_reg};
            b2_v1_next = b1_y_reg;
            b2_m2_next = gxgy_reg[13:0];
            b2_v2_next = b1_z_reg;
            b2_v3_next = b1_x_reg;
        end
    end

    assign b3_sum = b3_base_reg + GW'(b3_p1_reg) + b3_p2_reg + GW'(b3_v3_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_vld_reg  <= 1'b0;
            b2_vld_reg  <= 1'b0;
            b3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (en_b) begin
            b1_vld_reg  <= ex_vld_reg;
            b2_vld_reg  <= b1_vld_reg;
            b3_vld_reg  <= b2_vld_reg;
            out_vld_reg <= b3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_b) begin
            b1_x_reg    <= e_x;
            b1_y_reg    <= e_y;
            b1_z_reg    <= e_z;
            b1_err_reg  <= ex_reg.err;
            b1_last_reg <= e_last;

            b2_x_reg    <= b1_x_reg;
            b2_y_reg    <= b1_y_reg;
            b2_z_reg    <= b1_z_reg;
            b2_err_reg  <= b1_err_reg;
            b2_last_reg <= b1_last_reg;
            b2_base_reg <= b2_base_next;
            b2_m1_reg   <= b2_m1_next;
            b2_v1_reg   <= b2_v1_next;
            b2_m2_reg   <= b2_m2_next;
            b2_v2_reg   <= b2_v2_next;
            b2_v3_reg   <= b2_v3_next;

            b3_x_reg    <= b2_x_reg;
            b3_y_reg    <= b2_y_reg;
            b3_z_reg    <= b2_z_reg;
            b3_err_reg  <= b2_err_reg;
            b3_last_reg <= b2_last_reg;
            b3_base_reg <= b2_base_reg;
            b3_p1_reg   <= b2_m1_reg * b2_v1_reg;
            b3_p2_reg   <= b2_m2_reg * b2_v2_reg;
            b3_v3_reg   <= b2_v3_reg;

            out_index_reg <= b3_err_reg ? '0 : b3_sum[IDX_W-1:0];
            out_x_reg     <= b3_err_reg ? '0 : b3_x_reg;
            out_y_reg     <= b3_err_reg ? '0 : b3_y_reg;
            out_z_reg     <= b3_err_reg ? '0 : b3_z_reg;
            out_last_reg  <= b3_last_reg;
            out_err_reg   <= b3_err_reg;
        end
    end

    assign m_valid           = out_vld_reg;
    assign m_out_index       = out_index_reg;
    assign m_out_x           = out_x_reg;
    assign m_out_y           = out_y_reg;
    assign m_out_z           = out_z_reg;
    assign m_out_last        = out_last_reg;
    assign m_out_range_error = out_err_reg;

endmodule
